@@ src/apst_pkg.sv @@
// ----------------------------------------------------------------------------
// Access point sighting table package
// Shared widths, codes and the table row layout of the sighting table.
// ----------------------------------------------------------------------------
package apst_pkg;

    // Number of table slots and the widths that follow from it.
    localparam int TABLE_DEPTH = 64;
    localparam int SLOT_W      = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // Fixed field widths.
    localparam int KEY_W    = 48;
    localparam int TIME_W   = 32;
    localparam int HITS_W   = 32;
    localparam int SLOT_O_W = 6;
    localparam int USED_O_W = 7;

    typedef enum logic [1:0] {
        ACT_OBSERVE = 2'd0,
        ACT_APPEND  = 2'd1,
        ACT_CLEAR   = 2'd2,
        ACT_SPARE   = 2'd3
    } t_action;

    typedef enum logic [2:0] {
        ST_UPDATED    = 3'd0,
        ST_INSERTED   = 3'd1,
        ST_SKIP       = 3'd2,
        ST_DROPPED    = 3'd3,
        ST_BASE_ADDED = 3'd4,
        ST_CLEARED    = 3'd5
    } t_status;

    // One table row: all stored fields of one access point.
    typedef struct packed {
        logic [KEY_W-1:0]  key;
        logic signed [7:0] signal;
        logic [7:0]        channel;
        logic              protect;
        logic [TIME_W-1:0] first;
        logic [TIME_W-1:0] last;
        logic [HITS_W-1:0] hits;
    } t_row;

endpackage

@@ src/access_point_sighting_table.sv @@
// ----------------------------------------------------------------------------
// Access point sighting table
// Learning table of access points keyed by 48-bit hardware address.
// ----------------------------------------------------------------------------
// Usage: one transaction on the input channel (i_in_valid / o_in_stall) carries
// an action and one sighting. Every input transaction yields exactly one
// result transaction on the output channel (o_out_valid / i_out_stall).
// An observe walks the valid slots from slot 0 with a single key comparator
// fed by the one read port of the table memory; one slot is compared per
// cycle. A hit ends the search at the matching slot, a miss at the last valid
// slot; the commit state then writes the row back and loads the result
// register. Appends, clears and observes on an empty table go straight from
// idle to the commit state. The key search makes an observe take longer the
// more slots are in use, with a table of 64 slots at most.
// The block takes one item at a time: o_in_stall is high from acceptance
// until the result is loaded into the output register. A waiting result does
// not block acceptance of the next item, but that item's commit waits while
// the receiver stalls, and the shown result holds its value meanwhile.
// Reset empties the table (entry and baseline counts zero), clears the drop
// counter and the output valid; the table memory itself is not cleared.
// ----------------------------------------------------------------------------
module access_point_sighting_table (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // Input channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [1:0]         i_action,
    input  logic [47:0]        i_hw_address,
    input  logic signed [7:0]  i_signal_dbm,
    input  logic [7:0]         i_radio_channel,
    input  logic               i_is_protected,
    input  logic [31:0]        i_now_ms,
    input  logic               i_last_of_scan,
    // Output channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [2:0]         o_status,
    output logic [5:0]         o_entry_slot,
    output logic [31:0]        o_sightings,
    output logic [31:0]        o_first_seen_ms,
    output logic [6:0]         o_entries_used,
    output logic [31:0]        o_dropped_total,
    output logic               o_scan_done
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SEARCH,
        S_COMMIT
    } t_state;

    // Sequencer state and counters.
    t_state                      r_state, n_state;
    logic [apst_pkg::CNT_W-1:0]  r_used, n_used;
    logic [apst_pkg::CNT_W-1:0]  r_base, n_base;
    logic [31:0]                 r_miss, n_miss;
    logic [apst_pkg::CNT_W-1:0]  r_idx, n_idx;
    logic                        r_pend, n_pend;
    logic [apst_pkg::SLOT_W-1:0] r_pidx, n_pidx;
    logic                        r_found, n_found;
    logic [apst_pkg::SLOT_W-1:0] r_m, n_m;

    // Captured input item.
    apst_pkg::t_action           r_action;
    logic [47:0]                 r_key;
    logic signed [7:0]           r_signal;
    logic [7:0]                  r_chan;
    logic                        r_prot;
    logic [31:0]                 r_now;
    logic                        r_last;

    // Output register.
    logic                        r_out_valid, n_out_valid;
    apst_pkg::t_status           r_status, n_status;
    logic [5:0]                  r_slot_o, n_slot_o;
    logic [31:0]                 r_hits_o, n_hits_o;
    logic [31:0]                 r_first_o, n_first_o;
    logic [6:0]                  r_used_o, n_used_o;
    logic                        r_scan_o, n_scan_o;

    // Table memory with one read and one write port.
    apst_pkg::t_row              mem [apst_pkg::TABLE_DEPTH];
    apst_pkg::t_row              r_rd_row;
    logic                        mem_re;
    logic                        mem_we;
    logic [apst_pkg::SLOT_W-1:0] mem_raddr;
    logic [apst_pkg::SLOT_W-1:0] mem_waddr;
    apst_pkg::t_row              mem_wrow;

    // Working signals.
    logic                        accept;
    logic                        out_free;
    logic                        key_match;
    logic                        last_cmp;
    logic                        full;
    logic [apst_pkg::SLOT_W-1:0] free_slot;
    logic [apst_pkg::SLOT_W-1:0] res_slot;
    logic [apst_pkg::CNT_W-1:0]  used_after;
    logic [apst_pkg::SLOT_W+5:0] slot_ext;
    logic [apst_pkg::CNT_W+6:0]  used_ext;

    assign o_in_stall      = (r_state != S_IDLE);
    assign accept          = i_in_valid && !o_in_stall;
    assign out_free        = !r_out_valid || !i_out_stall;

    assign full            = (r_used == apst_pkg::CNT_W'(apst_pkg::TABLE_DEPTH));
    assign free_slot       = r_used[apst_pkg::SLOT_W-1:0];

    // The comparator looks at the row read in the previous cycle.
    assign key_match       = r_pend && (r_rd_row.key == r_key);
    assign last_cmp        = r_pend &&
                             (apst_pkg::CNT_W'(r_pidx) + apst_pkg::CNT_W'(1) == r_used);

    assign slot_ext        = (apst_pkg::SLOT_W + 6)'(res_slot);
    assign used_ext        = (apst_pkg::CNT_W + 7)'(used_after);

    always_comb begin
        n_state     = r_state;
        n_used      = r_used;
        n_base      = r_base;
        n_miss      = r_miss;
        n_idx       = r_idx;
        n_pend      = r_pend;
        n_pidx      = r_pidx;
        n_found     = r_found;
        n_m         = r_m;
        n_out_valid = r_out_valid && i_out_stall;
        n_status    = r_status;
        n_slot_o    = r_slot_o;
        n_hits_o    = r_hits_o;
        n_first_o   = r_first_o;
        n_used_o    = r_used_o;
        n_scan_o    = r_scan_o;
        mem_re      = 1'b0;
        mem_raddr   = r_idx[apst_pkg::SLOT_W-1:0];
        mem_we      = 1'b0;
        mem_waddr   = free_slot;
        mem_wrow    = '{key: r_key, signal: r_signal, channel: r_chan, protect: r_prot,
                        first: r_now, last: r_now, hits: 32'd1};
        res_slot    = '0;
        used_after  = r_used;

        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_idx   = '0;
                    n_pend  = 1'b0;
                    n_found = 1'b0;
                    if (apst_pkg::t_action'(i_action) == apst_pkg::ACT_OBSERVE &&
                        r_used != '0) begin
                        n_state = S_SEARCH;
                    end else begin
                        n_state = S_COMMIT;
                    end
                end
            end

            S_SEARCH: begin
                // Issue the next slot read unless a match must keep the row.
                if (r_idx < r_used && !key_match) begin
                    mem_re = 1'b1;
                    n_idx  = r_idx + apst_pkg::CNT_W'(1);
                    n_pidx = r_idx[apst_pkg::SLOT_W-1:0];
                    n_pend = 1'b1;
                end else begin
                    n_pend = 1'b0;
                end
                if (key_match) begin
                    n_found = 1'b1;
                    n_m     = r_pidx;
                    n_state = S_COMMIT;
                end else if (last_cmp) begin
                    n_state = S_COMMIT;
                end
            end

            S_COMMIT: begin
                if (out_free) begin
                    n_state     = S_IDLE;
                    n_out_valid = 1'b1;
                    n_scan_o    = r_last;
                    n_hits_o    = '0;
                    n_first_o   = '0;
                    unique case (r_action)
                        apst_pkg::ACT_OBSERVE: begin
                            if (r_found) begin
                                res_slot  = r_m;
                                n_first_o = r_rd_row.first;
                                if (apst_pkg::CNT_W'(r_m) < r_base) begin
                                    // Baseline entries are never refreshed.
                                    n_status = apst_pkg::ST_SKIP;
                                    n_hits_o = r_rd_row.hits;
                                end else begin
                                    n_status       = apst_pkg::ST_UPDATED;
                                    mem_we         = 1'b1;
                                    mem_waddr      = r_m;
                                    mem_wrow.first = r_rd_row.first;
                                    mem_wrow.hits  = (r_rd_row.hits == '1) ? r_rd_row.hits
                                                                           : r_rd_row.hits + 32'd1;
                                    n_hits_o       = mem_wrow.hits;
                                end
                            end else if (full) begin
                                n_status = apst_pkg::ST_DROPPED;
                                n_miss   = r_miss + 32'd1;
                            end else begin
                                n_status   = apst_pkg::ST_INSERTED;
                                mem_we     = 1'b1;
                                res_slot   = free_slot;
                                n_hits_o   = 32'd1;
                                n_first_o  = r_now;
                                used_after = r_used + apst_pkg::CNT_W'(1);
                            end
                        end
                        apst_pkg::ACT_APPEND: begin
                            if (full) begin
                                n_status = apst_pkg::ST_DROPPED;
                            end else begin
                                // Appending protects every entry below it too.
                                n_status      = apst_pkg::ST_BASE_ADDED;
                                mem_we        = 1'b1;
                                mem_wrow.hits = '0;
                                res_slot      = free_slot;
                                n_first_o     = r_now;
                                used_after    = r_used + apst_pkg::CNT_W'(1);
                                n_base        = used_after;
                            end
                        end
                        default: begin
                            n_status   = apst_pkg::ST_CLEARED;
                            used_after = '0;
                            n_base     = '0;
                            n_miss     = '0;
                        end
                    endcase
                    n_used   = used_after;
                    n_slot_o = slot_ext[5:0];
                    n_used_o = used_ext[6:0];
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_used      <= '0;
            r_base      <= '0;
            r_miss      <= '0;
            r_idx       <= '0;
            r_pend      <= 1'b0;
            r_found     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_used      <= n_used;
            r_base      <= n_base;
            r_miss      <= n_miss;
            r_idx       <= n_idx;
            r_pend      <= n_pend;
            r_found     <= n_found;
            r_out_valid <= n_out_valid;
        end
        r_pidx    <= n_pidx;
        r_m       <= n_m;
        r_status  <= n_status;
        r_slot_o  <= n_slot_o;
        r_hits_o  <= n_hits_o;
        r_first_o <= n_first_o;
        r_used_o  <= n_used_o;
        r_scan_o  <= n_scan_o;
        if (accept) begin
            r_action <= apst_pkg::t_action'(i_action);
            r_key    <= i_hw_address;
            r_signal <= i_signal_dbm;
            r_chan   <= i_radio_channel;
            r_prot   <= i_is_protected;
            r_now    <= i_now_ms;
            r_last   <= i_last_of_scan;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wrow;
        end
        if (mem_re) begin
            r_rd_row <= mem[mem_raddr];
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_status;
    assign o_entry_slot    = r_slot_o;
    assign o_sightings     = r_hits_o;
    assign o_first_seen_ms = r_first_o;
    assign o_entries_used  = r_used_o;
    assign o_dropped_total = r_miss;
    assign o_scan_done     = r_scan_o;

endmodule
